@@ rtl/core/spa_pkg.sv @@
// Shared types and constants for the slot pool allocator.
// No dependencies; every other file of the block uses this package.
`timescale 1ns / 1ps

package spa_pkg;

    localparam int POOL_SLOTS_DEF  = 8;   // default pool depth
    localparam int RESET_POOL_SIZE = 8;   // pool_size after reset, before clamping
    localparam int SLOT_W          = 3;   // slot number width
    localparam int SIZE_W          = 4;   // pool_size register width
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;   // bit 2 is the register index
    localparam int REG_IDX_W       = 1;

    localparam logic [REG_IDX_W-1:0] REG_POOL_SIZE = 1'b0;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_IGNORED = 1'b1;

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [SIZE_W-1:0] size_t;

    typedef enum logic
    {
        REQ_GRAB    = 1'b0,
        REQ_RELEASE = 1'b1
    } req_kind_t;

    typedef struct packed
    {
        req_kind_t req_type;
        slot_t     slot;
    } req_t;

    typedef struct packed
    {
        slot_t slot_out;
        logic  recycled;
        logic  status;
    } result_t;

    typedef struct packed
    {
        logic  init;   // one-cycle pulse: rebuild both lists
        size_t size;   // clamped size that goes with the pulse
    } cfg_t;

endpackage

@@ rtl/core/slot_pool_allocator_recycle_oldest_top.sv @@
// Top level of the slot pool allocator with oldest-first reuse.
// Depends on spa_pkg, spa_apb_regs and spa_engine.
`timescale 1ns / 1ps

// Channel   Signals                                   Direction  Beat moves when
// --------  ----------------------------------------  ---------  ----------------------
// request   in_valid, in_stall, req_type, slot_in     in         in_valid && !in_stall
// result    out_valid, out_stall, slot_out,           out        out_valid && !out_stall
//           recycled, status
// config    psel, penable, pwrite, paddr, pwdata,     in/out     psel && penable &&
//           prdata, pready                                       pwrite (pready tied high)
//
// One request beat per cycle sustained while out_stall is low; each request
// passes the input register, then the result register. The whole list update
// for a request sits between those registers: a parallel compare over the
// in-use list and a one-step shift of the free or in-use list.
// Reset (rst_n, async) gives pool_size 8 clamped to POOL_SLOTS, all slots free.
// A result stalled by out_stall holds the result register; the input register
// then fills and in_stall rises until the result beat leaves.

module slot_pool_allocator_recycle_oldest_top #(
    parameter int POOL_SLOTS = spa_pkg::POOL_SLOTS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            req_type,
    input  logic [spa_pkg::SLOT_W-1:0]      slot_in,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [spa_pkg::SLOT_W-1:0]      slot_out,
    output logic                            recycled,
    output logic                            status,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [spa_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [spa_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [spa_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int CW = $clog2(POOL_SLOTS + 1);
    localparam int IW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
    localparam int RST_SIZE = (spa_pkg::RESET_POOL_SIZE > POOL_SLOTS) ?
                              POOL_SLOTS : spa_pkg::RESET_POOL_SIZE;

    // configuration
    spa_pkg::size_t pool_size;
    spa_pkg::cfg_t  cfg;

    // handshake and pipeline control
    logic in_take;
    logic out_take;
    logic advance;
    logic in_v_reg,  in_v_next;
    logic out_v_reg, out_v_next;

    // request and result registers
    spa_pkg::req_t    req_reg,  req_next;
    spa_pkg::result_t res_reg,  res_next;
    spa_pkg::result_t res_comb;

    // list state
    spa_pkg::slot_t [POOL_SLOTS-1:0] free_reg, free_next, free_upd;
    spa_pkg::slot_t [POOL_SLOTS-1:0] used_reg, used_next, used_upd;
    logic [CW-1:0] free_cnt_reg, free_cnt_next, free_cnt_upd;
    logic [CW-1:0] used_cnt_reg, used_cnt_next, used_cnt_upd;

    spa_apb_regs #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pool_size (pool_size),
        .cfg       (cfg)
    );

    spa_engine #(
        .POOL_SLOTS (POOL_SLOTS),
        .CW         (CW),
        .IW         (IW)
    ) u_engine (
        .req        (req_reg),
        .pool_size  (pool_size),
        .free_q     (free_reg),
        .free_cnt_q (free_cnt_reg),
        .used_q     (used_reg),
        .used_cnt_q (used_cnt_reg),
        .free_n     (free_upd),
        .free_cnt_n (free_cnt_upd),
        .used_n     (used_upd),
        .used_cnt_n (used_cnt_upd),
        .res        (res_comb)
    );

    // The request in the input register moves on whenever the result
    // register is empty or its beat is being taken this cycle.
    assign out_take = out_v_reg && !out_stall;
    assign advance  = in_v_reg && (!out_v_reg || !out_stall);
    assign in_stall = in_v_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        in_v_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_v_reg);
        out_v_next = advance ? 1'b1 : (out_take ? 1'b0 : out_v_reg);
        req_next   = req_reg;
        if (in_take)
        begin
            req_next.req_type = spa_pkg::req_kind_t'(req_type);
            req_next.slot     = slot_in;
        end
        res_next = advance ? res_comb : res_reg;
    end

    // List state: a pool_size write rebuilds everything, otherwise the
    // engine's update lands when the request advances.
    always_comb
    begin
        free_next     = free_reg;
        used_next     = used_reg;
        free_cnt_next = free_cnt_reg;
        used_cnt_next = used_cnt_reg;
        priority if (cfg.init)
        begin
            for (int i = 0; i < POOL_SLOTS; i++)
                free_next[i] = (32'(i) < 32'(cfg.size)) ? spa_pkg::SLOT_W'(i) : '0;
            free_cnt_next = CW'(cfg.size);
            used_cnt_next = '0;
        end
        else if (advance)
        begin
            free_next     = free_upd;
            used_next     = used_upd;
            free_cnt_next = free_cnt_upd;
            used_cnt_next = used_cnt_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg     <= 1'b0;
            out_v_reg    <= 1'b0;
            free_cnt_reg <= CW'(RST_SIZE);
            used_cnt_reg <= '0;
            for (int i = 0; i < POOL_SLOTS; i++)
                free_reg[i] <= (i < RST_SIZE) ? spa_pkg::SLOT_W'(i) : '0;
        end
        else
        begin
            in_v_reg     <= in_v_next;
            out_v_reg    <= out_v_next;
            free_cnt_reg <= free_cnt_next;
            used_cnt_reg <= used_cnt_next;
            free_reg     <= free_next;
        end
    end

    // payload: no reset; in-use entries beyond the count are never read
    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        res_reg  <= res_next;
        used_reg <= used_next;
    end

    assign out_valid = out_v_reg;
    assign slot_out  = res_reg.slot_out;
    assign recycled  = res_reg.recycled;
    assign status    = res_reg.status;

endmodule

@@ rtl/core/spa_apb_regs.sv @@
// APB register file for the slot pool allocator: holds pool_size.
// Depends on spa_pkg.
`timescale 1ns / 1ps

module spa_apb_regs #(
    parameter int POOL_SLOTS = spa_pkg::POOL_SLOTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [spa_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [spa_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [spa_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output spa_pkg::size_t                    pool_size,
    output spa_pkg::cfg_t                     cfg
);

    localparam int RST_SIZE = (spa_pkg::RESET_POOL_SIZE > POOL_SLOTS) ?
                              POOL_SLOTS : spa_pkg::RESET_POOL_SIZE;

    spa_pkg::size_t size_reg;
    spa_pkg::size_t size_next;
    spa_pkg::size_t wr_raw;
    spa_pkg::size_t wr_clamped;
    logic           wr_hit;

    assign pready = 1'b1;
    assign wr_raw = pwdata[spa_pkg::SIZE_W-1:0];
    assign wr_hit = psel && penable && pwrite && pready &&
                    (paddr[2] == spa_pkg::REG_POOL_SIZE);

    always_comb
    begin
        priority if (wr_raw == '0)
            wr_clamped = spa_pkg::size_t'(1);
        else if (32'(wr_raw) > POOL_SLOTS)
            wr_clamped = spa_pkg::size_t'(POOL_SLOTS);
        else
            wr_clamped = wr_raw;
    end

    assign size_next = wr_hit ? wr_clamped : size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            size_reg <= spa_pkg::size_t'(RST_SIZE);
        else
            size_reg <= size_next;
    end

    always_comb
    begin
        if (paddr[2] == spa_pkg::REG_POOL_SIZE)
            prdata = {{(spa_pkg::APB_DATA_W-spa_pkg::SIZE_W){1'b0}}, size_reg};
        else
            prdata = '0;
    end

    assign pool_size = size_reg;
    assign cfg.init  = wr_hit;
    assign cfg.size  = wr_clamped;

endmodule

@@ rtl/core/spa_engine.sv @@
// Combinational list update for one request: free-list pop/push, in-use
// append, oldest-first rotate and removal by parallel compare. Depends on spa_pkg.
`timescale 1ns / 1ps

module spa_engine #(
    parameter int POOL_SLOTS = spa_pkg::POOL_SLOTS_DEF,
    parameter int CW         = $clog2(POOL_SLOTS + 1),
    parameter int IW         = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1
) (
    input  spa_pkg::req_t                     req,
    input  spa_pkg::size_t                    pool_size,
    input  spa_pkg::slot_t [POOL_SLOTS-1:0]   free_q,
    input  logic [CW-1:0]                     free_cnt_q,
    input  spa_pkg::slot_t [POOL_SLOTS-1:0]   used_q,
    input  logic [CW-1:0]                     used_cnt_q,
    output spa_pkg::slot_t [POOL_SLOTS-1:0]   free_n,
    output logic [CW-1:0]                     free_cnt_n,
    output spa_pkg::slot_t [POOL_SLOTS-1:0]   used_n,
    output logic [CW-1:0]                     used_cnt_n,
    output spa_pkg::result_t                  res
);

    logic [POOL_SLOTS-1:0] match;
    logic                  found;
    logic [IW-1:0]         pos;
    logic                  in_range;
    spa_pkg::slot_t        taken;

    always_comb
    begin
        free_n     = free_q;
        used_n     = used_q;
        free_cnt_n = free_cnt_q;
        used_cnt_n = used_cnt_q;
        res.slot_out = '0;
        res.recycled = 1'b0;
        res.status   = spa_pkg::STATUS_OK;
        taken    = '0;
        found    = 1'b0;
        pos      = '0;
        in_range = ({1'b0, req.slot} < pool_size);

        // live in-use entries that hold the named slot
        for (int i = 0; i < POOL_SLOTS; i++)
            match[i] = (used_q[i] == req.slot) && (CW'(i) < used_cnt_q);

        // first match, oldest end wins
        for (int i = 0; i < POOL_SLOTS; i++)
        begin
            if (match[i] && !found)
            begin
                found = 1'b1;
                pos   = IW'(i);
            end
        end

        unique case (req.req_type)
            spa_pkg::REQ_GRAB:
            begin
                if ((free_cnt_q != '0) && (used_cnt_q < CW'(POOL_SLOTS)))
                begin
                    taken = free_q[0];
                    for (int i = 0; i < POOL_SLOTS - 1; i++)
                        free_n[i] = free_q[i+1];
                    free_cnt_n = free_cnt_q - CW'(1);
                    used_n[used_cnt_q[IW-1:0]] = taken;
                    used_cnt_n = used_cnt_q + CW'(1);
                    res.slot_out = taken;
                end
                else if (used_cnt_q != '0)
                begin
                    // no free slot: rotate oldest in-use slot to the young end
                    taken = used_q[0];
                    for (int i = 0; i < POOL_SLOTS; i++)
                    begin
                        if (CW'(i) + CW'(1) == used_cnt_q)
                            used_n[i] = taken;
                        else if ((i < POOL_SLOTS - 1) && (CW'(i) + CW'(1) < used_cnt_q))
                            used_n[i] = used_q[(i < POOL_SLOTS - 1) ? i + 1 : i];
                    end
                    res.slot_out = taken;
                    res.recycled = 1'b1;
                end
            end
            spa_pkg::REQ_RELEASE:
            begin
                res.slot_out = req.slot;
                if (in_range && found && (free_cnt_q < CW'(POOL_SLOTS)))
                begin
                    for (int i = 0; i < POOL_SLOTS - 1; i++)
                    begin
                        if (IW'(i) >= pos)
                            used_n[i] = used_q[i+1];
                    end
                    used_cnt_n = used_cnt_q - CW'(1);
                    free_n[free_cnt_q[IW-1:0]] = req.slot;
                    free_cnt_n = free_cnt_q + CW'(1);
                end
                else
                    res.status = spa_pkg::STATUS_IGNORED;
            end
        endcase
    end

endmodule

@@ tb/sv/slot_pool_allocator_recycle_oldest_top_tb.sv @@
// Self-checking testbench for slot_pool_allocator_recycle_oldest_top.
// Needs spa_pkg and the block's RTL; a scoreboard class predicts every result beat.
`timescale 1ns / 1ps

module slot_pool_allocator_recycle_oldest_top_tb;

    localparam int POOL      = spa_pkg::POOL_SLOTS_DEF;
    localparam int HOLD_LEN  = 80;        // long receiver hold-off in pressure phases
    localparam int LIMIT     = 200000;    // cycle ceiling for the whole run
    localparam int N_PHASES  = 10;
    localparam int PER_PHASE = 123;

    // Free list and in-use list, both oldest first, plus the beats still owed
    class slot_scoreboard;
        int unsigned      pool_size;
        spa_pkg::slot_t   free_list[$];
        spa_pkg::slot_t   used_list[$];
        spa_pkg::result_t owed[$];
        int unsigned      errors;

        function void rebuild(spa_pkg::size_t size);
            int unsigned n;
            n = size;
            if (n < 1)
                n = 1;
            if (n > POOL)
                n = POOL;
            pool_size = n;
            free_list.delete();
            used_list.delete();
            for (int i = 0; i < n; i++)
                free_list.insert(free_list.size(), spa_pkg::slot_t'(i));
        endfunction

        // Called on every accepted request beat, in acceptance order
        function void note_request(spa_pkg::req_kind_t kind, spa_pkg::slot_t slot);
            spa_pkg::result_t r;
            spa_pkg::slot_t   taken;
            int               pos;
            r.slot_out = '0;
            r.recycled = 1'b0;
            r.status   = spa_pkg::STATUS_OK;
            if (kind == spa_pkg::REQ_GRAB)
            begin
                if (free_list.size() > 0)
                begin
                    taken = free_list[0];
                    free_list.delete(0);
                    used_list.insert(used_list.size(), taken);
                    r.slot_out = taken;
                end
                else if (used_list.size() > 0)
                begin
                    // no free slot: the longest-used one goes to the young end
                    taken = used_list[0];
                    used_list.delete(0);
                    used_list.insert(used_list.size(), taken);
                    r.slot_out = taken;
                    r.recycled = 1'b1;
                end
            end
            else
            begin
                r.slot_out = slot;
                pos = -1;
                if (slot < pool_size)
                begin
                    for (int i = 0; i < used_list.size(); i++)
                        if (pos < 0 && used_list[i] == slot)
                            pos = i;
                end
                if (pos < 0 || free_list.size() >= POOL)
                    r.status = spa_pkg::STATUS_IGNORED;
                else
                begin
                    used_list.delete(pos);
                    free_list.insert(free_list.size(), slot);
                end
            end
            owed.insert(owed.size(), r);
        endfunction

        function void check_result(spa_pkg::result_t got);
            spa_pkg::result_t want;
            if (owed.size() == 0)
            begin
                $display("%0t: result beat with nothing owed: slot_out %0d recycled %0b",
                         $time, got.slot_out, got.recycled);
                errors++;
                return;
            end
            want = owed[0];
            owed.delete(0);
            if (got.slot_out !== want.slot_out)
            begin
                $display("%0t: slot_out expected %0d got %0d", $time,
                         want.slot_out, got.slot_out);
                errors++;
            end
            if (got.recycled !== want.recycled)
            begin
                $display("%0t: recycled expected %0b got %0b", $time,
                         want.recycled, got.recycled);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $display("%0t: status expected %0b got %0b", $time,
                         want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_stall;
    logic                           req_type;
    logic [spa_pkg::SLOT_W-1:0]     slot_in;
    logic                           out_valid;
    logic                           out_stall;
    logic [spa_pkg::SLOT_W-1:0]     slot_out;
    logic                           recycled;
    logic                           status;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [spa_pkg::APB_ADDR_W-1:0] paddr;
    logic [spa_pkg::APB_DATA_W-1:0] pwdata;
    logic [spa_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;

    slot_scoreboard sb;
    int unsigned    send_idle_pct;
    int unsigned    stall_pct;
    bit             pressure_on;
    int unsigned    hold_count;
    int unsigned    cycles;

    slot_pool_allocator_recycle_oldest_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .slot_in   (slot_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .slot_out  (slot_out),
        .recycled  (recycled),
        .status    (status),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #2 clk = ~clk;

    // Result side: check accepted beats, drive out_stall, watch the clock budget
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            if (rst_n && out_valid && !out_stall)
                sb.check_result('{slot_out: slot_out, recycled: recycled, status: status});
            if (pressure_on && hold_count < HOLD_LEN)
            begin
                // long hold-off: request side keeps offering until in_stall rises
                out_stall <= 1'b1;
                hold_count++;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < stall_pct);
                if (!pressure_on)
                    hold_count = 0;
            end
        end
    end

    task automatic send_request(input spa_pkg::req_kind_t kind, input spa_pkg::slot_t slot);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= kind;
        slot_in  <= slot;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(kind, slot);
    endtask

    task automatic random_request();
        spa_pkg::req_kind_t kind;
        spa_pkg::slot_t     slot;
        kind = ($urandom_range(99) < 45) ? spa_pkg::REQ_GRAB : spa_pkg::REQ_RELEASE;
        slot = spa_pkg::slot_t'($urandom_range(7));
        // mostly release a slot that is really in use, so the lists keep moving
        if (kind == spa_pkg::REQ_RELEASE && sb.used_list.size() > 0 &&
            $urandom_range(99) < 70)
            slot = sb.used_list[$urandom_range(sb.used_list.size() - 1)];
        send_request(kind, slot);
    endtask

    // Drain every owed beat, then let the two pipeline registers empty
    task automatic settle();
        in_valid    <= 1'b0;
        stall_pct    = 0;
        pressure_on  = 1'b0;
        @(posedge clk);
        while (sb.owed.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(input logic [spa_pkg::APB_ADDR_W-1:0] addr,
                             input logic [spa_pkg::APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2 +: spa_pkg::REG_IDX_W] == spa_pkg::REG_POOL_SIZE)
            sb.rebuild(spa_pkg::size_t'(data[spa_pkg::SIZE_W-1:0]));
    endtask

    initial
    begin
        spa_pkg::size_t                 phase_size[N_PHASES];
        logic [spa_pkg::APB_DATA_W-1:0] wdata;

        phase_size = '{4'd8, 4'd1, 4'd5, 4'd0, 4'd3, 4'd15, 4'd8, 4'd2, 4'd9, 4'd7};
        sb = new();
        sb.rebuild(spa_pkg::size_t'(spa_pkg::RESET_POOL_SIZE));
        clk           = 1'b0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        req_type      = spa_pkg::REQ_GRAB;
        slot_in       = '0;
        out_stall     = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        pressure_on   = 1'b0;
        hold_count    = 0;
        cycles        = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full pool of eight: take every slot, then run dry and recycle
        repeat (10) send_request(spa_pkg::REQ_GRAB, spa_pkg::slot_t'(0));
        send_request(spa_pkg::REQ_RELEASE, spa_pkg::slot_t'(3));
        send_request(spa_pkg::REQ_RELEASE, spa_pkg::slot_t'(3));    // already free
        send_request(spa_pkg::REQ_GRAB, spa_pkg::slot_t'(7));
        settle();
        reg_write(3'd4, 32'd2);                   // no register there
        reg_write(3'd0, 32'd3);

        // Pool of three: out-of-range and free slots are refused
        send_request(spa_pkg::REQ_RELEASE, spa_pkg::slot_t'(7));
        send_request(spa_pkg::REQ_RELEASE, spa_pkg::slot_t'(0));
        repeat (4) send_request(spa_pkg::REQ_GRAB, spa_pkg::slot_t'(5));
        send_request(spa_pkg::REQ_RELEASE, spa_pkg::slot_t'(1));
        send_request(spa_pkg::REQ_RELEASE, spa_pkg::slot_t'(2));
        send_request(spa_pkg::REQ_GRAB, spa_pkg::slot_t'(0));
        settle();
        reg_write(3'd0, 32'd0);                   // zero acts as a pool of one

        send_request(spa_pkg::REQ_GRAB, spa_pkg::slot_t'(0));
        send_request(spa_pkg::REQ_GRAB, spa_pkg::slot_t'(0));
        send_request(spa_pkg::REQ_RELEASE, spa_pkg::slot_t'(0));
        send_request(spa_pkg::REQ_RELEASE, spa_pkg::slot_t'(0));
        settle();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            wdata = {28'd0, phase_size[ph]};
            if (ph % 2 == 1)
                wdata = ($urandom() & 32'hFFFF_FFF0) | wdata;
            reg_write(3'd0, wdata);
            case (ph % 4)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 51;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 51;
                end
                default:
                begin
                    send_idle_pct = 25;
                    stall_pct     = 25;
                end
            endcase
            if (ph == 4 || ph == 8)
                pressure_on = 1'b1;
            for (int n = 0; n < PER_PHASE; n++)
                random_request();
            settle();
        end

        send_idle_pct = 0;
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
